/* src/sae_pkg.sv */
// ----------------------------------------------------------------------------
// sae_pkg
// Shared constants, types and AES-128 helper functions for the seed expander.
// ----------------------------------------------------------------------------
package sae_pkg;

   localparam int MaxGroupDefault = 8;
   localparam int BlockBytes      = 16;
   localparam int WordBytes       = 8;
   localparam int Rounds          = 10;

   localparam logic [0:0] CsrBitWidth  = 1'b0;
   localparam logic [0:0] CsrGroupSize = 1'b1;

   typedef logic [127:0] block_type;

   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = a[7] ? ((a << 1) ^ 8'h1b) : (a << 1);
   endfunction

   function automatic logic [7:0] sbox(input logic [7:0] x);
      logic [7:0] t [0:255];
      t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      sbox = t[x];
   endfunction

   // byte i of a block sits at bits [8i+7:8i]
   function automatic block_type sub_shift(input block_type s);
      block_type n;
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            n[8*(r+4*c) +: 8] = sbox(s[8*(r+4*((c+r)%4)) +: 8]);
      sub_shift = n;
   endfunction

   function automatic block_type mix_columns(input block_type n);
      block_type s;
      logic [7:0] a0, a1, a2, a3;
      for (int c = 0; c < 4; c++) begin
         a0 = n[32*c +: 8]; a1 = n[32*c+8 +: 8]; a2 = n[32*c+16 +: 8]; a3 = n[32*c+24 +: 8];
         s[32*c +: 8]    = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
         s[32*c+8 +: 8]  = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
         s[32*c+16 +: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
         s[32*c+24 +: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
      mix_columns = s;
   endfunction

   function automatic block_type next_key(input block_type k, input logic [7:0] rcon);
      block_type o;
      logic [31:0] t;
      t = {sbox(k[103:96]), sbox(k[127:120]), sbox(k[119:112]), sbox(k[111:104] ^ 8'h00)};
      t = {sbox(k[103:96]), sbox(k[127:120]), sbox(k[119:112]), sbox(k[111:104])} ^
          {24'h0, rcon};
      o[31:0]   = k[31:0] ^ t;
      o[63:32]  = k[63:32] ^ o[31:0];
      o[95:64]  = k[95:64] ^ o[63:32];
      o[127:96] = k[127:96] ^ o[95:64];
      next_key = o;
   endfunction

endpackage

/* src/sae_stream_if.sv */
// ----------------------------------------------------------------------------
// sae_stream_if
// Valid/ready channel carrying a parameterised payload.
// ----------------------------------------------------------------------------
interface sae_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* src/seed_to_words_aes_expander.sv */
// ----------------------------------------------------------------------------
// seed_to_words_aes_expander
// Expands a 128-bit seed into words, directly or via AES-128 counter blocks.
//
//   channel  dir  payload
//   req      in   seed_low[63:0], seed_high[63:0]
//   rsp      out  word[63:0], last
//   csr      in   index[0:0], value[63:0]
//
// A seed is taken in one transfer, then nblocks = ceil(total/16) counter blocks
// are issued (one when direct); blocks pass a twelve-register pipeline holding
// the initial key addition, the rounds and the final key addition. The
// collector gathers a seed's blocks and then emits its words; it takes no block
// while emitting, so a block waiting at the pipeline end halts the pipeline,
// also under a stall on rsp. Reset clears valid bits, sets width 64, group 1.
// ----------------------------------------------------------------------------
module seed_to_words_aes_expander #(
   parameter int MAX_GROUP = sae_pkg::MaxGroupDefault
) (
   input  logic clock,
   input  logic reset,
   sae_stream_if.sink   req,
   sae_stream_if.source rsp,
   sae_stream_if.sink   csr
);
   localparam int NBlk = (MAX_GROUP * sae_pkg::WordBytes + 15) / 16;
   localparam int BW   = $clog2(NBlk + 1);
   localparam int GW   = $clog2(MAX_GROUP + 1);
   localparam int St   = sae_pkg::Rounds + 1;
   localparam int BufB = 16 * NBlk;

   logic [6:0] bit_width_ff;
   logic [3:0] group_size_ff;
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_width_ff  <= 7'd64;
         group_size_ff <= 4'd1;
      end else if (csr.valid) begin
         if (csr.data.index == sae_pkg::CsrBitWidth) bit_width_ff <= csr.data.value[6:0];
         else group_size_ff <= csr.data.value[3:0];
      end
   end

   // derived sizes
   logic [3:0] nbytes;
   logic [GW-1:0] groups;
   logic [7:0] total;
   logic direct;
   logic [BW-1:0] nblocks;
   always_comb begin
      nbytes = (bit_width_ff == 7'd0) ? 4'd1 : (bit_width_ff > 7'd64) ? 4'd8 :
               4'((8'(bit_width_ff) + 8'd7) >> 3);
      groups = (group_size_ff == 4'd0) ? GW'(1) :
               (32'(group_size_ff) > MAX_GROUP) ? GW'(MAX_GROUP) : GW'(group_size_ff);
      total  = 8'(nbytes) * 8'(groups);
      direct = total <= 8'd16;
      nblocks = BW'((total + 8'd15) >> 4);
   end

   // issue: one counter block per cycle into the round pipeline while it advances
   logic advance;
   logic busy_ff;
   logic [BW-1:0] blk_ff;
   logic [127:0] seed_ff;
   logic issue_v, issue_last;
   assign issue_v    = busy_ff;
   assign issue_last = direct || (blk_ff == nblocks - BW'(1));

   logic [St:0] v_ff;
   logic [St:0] l_ff;
   logic [St:0] d_ff;
   logic [127:0] s_ff [0:St];
   logic [127:0] k_ff [0:St];

   // collector
   logic [BufB*8-1:0] buf_ff;
   logic [BW-1:0] fill_ff;
   logic out_busy_ff;
   logic [GW-1:0] wi_ff;
   logic col_free;

   assign advance = !v_ff[St] || col_free;
   assign req.ready = !busy_ff && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         blk_ff  <= '0;
      end else if (advance) begin
         if (req.valid && req.ready) begin
            busy_ff <= 1'b1;
            blk_ff  <= '0;
            seed_ff <= {req.data.seed_high, req.data.seed_low};
         end else if (busy_ff) begin
            blk_ff <= blk_ff + BW'(1);
            if (issue_last) busy_ff <= 1'b0;
         end
      end
   end

   logic [7:0] rcon [0:9];
   assign rcon = '{8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (advance) begin
         v_ff <= {v_ff[St-1:0], issue_v};
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         l_ff[0] <= issue_last;
         d_ff[0] <= direct;
         k_ff[0] <= seed_ff;
         s_ff[0] <= direct ? seed_ff : ({64'h0, 64'(blk_ff)} ^ seed_ff);
         for (int i = 1; i <= St; i++) begin
            l_ff[i] <= l_ff[i-1];
            d_ff[i] <= d_ff[i-1];
            if (i <= sae_pkg::Rounds) begin
               k_ff[i] <= sae_pkg::next_key(k_ff[i-1], rcon[i-1]);
               s_ff[i] <= d_ff[i-1] ? s_ff[i-1] :
                  (i == sae_pkg::Rounds) ? sae_pkg::sub_shift(s_ff[i-1]) :
                  (sae_pkg::mix_columns(sae_pkg::sub_shift(s_ff[i-1])) ^
                   sae_pkg::next_key(k_ff[i-1], rcon[i-1]));
            end else begin
               k_ff[i] <= k_ff[i-1];
               s_ff[i] <= d_ff[i-1] ? s_ff[i-1] : (s_ff[i-1] ^ k_ff[i-1]);
            end
         end
      end
   end

   // stage St holds a finished block; collector accepts it unless emitting
   assign col_free = !out_busy_ff;
   logic [BufB*8-1:0] byte_sel;
   logic [63:0] word_v;
   logic [8:0] base;
   always_comb begin
      base = 9'(wi_ff) * 9'(nbytes);
      byte_sel = buf_ff >> {base, 3'b000};
      word_v = '0;
      for (int b = 0; b < 8; b++)
         if (b < nbytes) word_v[8*b +: 8] = byte_sel[8*b +: 8];
   end

   logic rsp_v_ff;
   logic [63:0] word_ff;
   logic last_ff;
   logic emit;
   assign emit = out_busy_ff && (!rsp_v_ff || rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         out_busy_ff <= 1'b0;
         wi_ff <= '0;
         rsp_v_ff <= 1'b0;
      end else begin
         if (v_ff[St] && col_free) begin
            buf_ff[128*fill_ff +: 128] <= s_ff[St];
            fill_ff <= l_ff[St] ? '0 : fill_ff + BW'(1);
            if (l_ff[St]) begin
               out_busy_ff <= 1'b1;
               wi_ff <= '0;
            end
         end
         if (emit) begin
            rsp_v_ff <= 1'b1;
            word_ff <= word_v;
            last_ff <= (wi_ff == groups - GW'(1));
            wi_ff <= wi_ff + GW'(1);
            if (wi_ff == groups - GW'(1)) out_busy_ff <= 1'b0;
         end else if (rsp.ready) begin
            rsp_v_ff <= 1'b0;
         end
      end
   end

   assign rsp.valid     = rsp_v_ff;
   assign rsp.data.word = word_ff;
   assign rsp.data.last = last_ff;
endmodule

/* bench/seed_to_words_aes_expander_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seed_to_words_aes_expander_tb
// Drives seeds through the expander under random idling on both channels
// and checks every word and last flag against a model kept in the bench (seed
// bytes when direct, else AES-128 counter mode); reconfigured between phases while idle.
// ----------------------------------------------------------------------------
module seed_to_words_aes_expander_tb;

   typedef struct packed {
      logic [63:0] seed_high;
      logic [63:0] seed_low;
   } seed_type;

   typedef struct packed {
      logic        last;
      logic [63:0] word;
   } word_type;

   typedef struct packed {
      logic [0:0]  index;
      logic [63:0] value;
   } csr_type;

   typedef struct {
      bit          is_csr;
      logic [0:0]  index;
      logic [63:0] value;
      logic [63:0] lo;
      logic [63:0] hi;
      bit          typed;
      logic [63:0] first_word;
   } row_type;

   typedef struct {
      logic [63:0] word;
      logic        last;
   } word_exp_type;

   logic clock;
   logic reset;
   int   errors;
   bit   calm;

   sae_stream_if #(.payload_type(seed_type)) req ();
   sae_stream_if #(.payload_type(word_type)) rsp ();
   sae_stream_if #(.payload_type(csr_type))  csr ();

   seed_to_words_aes_expander uut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr)
   );

   word_exp_type pending_words[$];
   logic [7:0]   sub_table [256];
   logic [6:0]   cur_width;
   logic [3:0]   cur_group;

   always begin
      clock = 1'b1; #10;
      clock = 1'b0; #10;
   end

   function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] r;
      r = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[0]) r ^= a;
         a = a[7] ? ((a << 1) ^ 8'h1b) : (a << 1);
         b = b >> 1;
      end
      return r;
   endfunction

   function automatic logic [7:0] calc_sub(input logic [7:0] x);
      logic [7:0] inv, p;
      inv = 8'h01;
      p   = x;
      for (int e = 254; e != 0; e = e >> 1) begin
         if (e & 1) inv = gmul(inv, p);
         p = gmul(p, p);
      end
      if (x == 8'h00) inv = 8'h00;
      return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]} ^
             {inv[3:0], inv[7:4]} ^ 8'h63;
   endfunction

   task automatic predict_words(input logic [63:0] lo, input logic [63:0] hi);
      logic [7:0]   buffer [128];
      logic [7:0]   seed [16];
      logic [7:0]   rk [176];
      logic [7:0]   s [16];
      logic [7:0]   n [16];
      logic [7:0]   t [4];
      logic [7:0]   rcon, tmp, a0, a1, a2, a3;
      int           nbytes, groups, total, nblocks;
      word_exp_type e;
      nbytes = (int'(cur_width) + 7) / 8;
      if (nbytes < 1) nbytes = 1;
      if (nbytes > 8) nbytes = 8;
      groups = cur_group;
      if (groups < 1) groups = 1;
      if (groups > 8) groups = 8;
      total = nbytes * groups;
      for (int i = 0; i < 8; i++) begin
         seed[i]     = lo[8*i +: 8];
         seed[8 + i] = hi[8*i +: 8];
      end
      for (int i = 0; i < 128; i++) buffer[i] = 8'h00;
      if (total <= 16) begin
         for (int i = 0; i < 16; i++) buffer[i] = seed[i];
      end else begin
         rcon = 8'h01;
         for (int i = 0; i < 16; i++) rk[i] = seed[i];
         for (int i = 4; i < 44; i++) begin
            for (int j = 0; j < 4; j++) t[j] = rk[4*(i-1)+j];
            if ((i & 3) == 0) begin
               tmp = t[0]; t[0] = t[1]; t[1] = t[2]; t[2] = t[3]; t[3] = tmp;
               for (int j = 0; j < 4; j++) t[j] = sub_table[t[j]];
               t[0] ^= rcon;
               rcon = gmul(rcon, 8'h02);
            end
            for (int j = 0; j < 4; j++) rk[4*i+j] = rk[4*(i-4)+j] ^ t[j];
         end
         nblocks = (total + 15) / 16;
         for (int b = 0; b < nblocks; b++) begin
            for (int i = 0; i < 16; i++) s[i] = ((i < 8) ? 8'(b >> (8*i)) : 8'h00) ^ rk[i];
            for (int rnd = 1; rnd <= 10; rnd++) begin
               for (int i = 0; i < 16; i++) s[i] = sub_table[s[i]];
               for (int c = 0; c < 4; c++)
                  for (int r = 0; r < 4; r++)
                     n[r+4*c] = s[r+4*((c+r)&3)];
               if (rnd != 10) begin
                  for (int c = 0; c < 4; c++) begin
                     a0 = n[4*c]; a1 = n[4*c+1]; a2 = n[4*c+2]; a3 = n[4*c+3];
                     s[4*c]   = gmul(a0, 2) ^ gmul(a1, 3) ^ a2 ^ a3;
                     s[4*c+1] = a0 ^ gmul(a1, 2) ^ gmul(a2, 3) ^ a3;
                     s[4*c+2] = a0 ^ a1 ^ gmul(a2, 2) ^ gmul(a3, 3);
                     s[4*c+3] = gmul(a0, 3) ^ a1 ^ a2 ^ gmul(a3, 2);
                  end
               end else begin
                  for (int i = 0; i < 16; i++) s[i] = n[i];
               end
               for (int i = 0; i < 16; i++) s[i] ^= rk[16*rnd+i];
            end
            for (int i = 0; i < 16; i++) buffer[16*b+i] = s[i];
         end
      end
      for (int i = 0; i < groups; i++) begin
         e.word = 64'h0;
         for (int b = 0; b < nbytes; b++) e.word[8*b +: 8] = buffer[i*nbytes+b];
         e.last = (i + 1 == groups);
         pending_words.push_back(e);
      end
   endtask

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      errors++;
   endtask

   // result sink with bursty back-pressure
   int rsp_hold;
   always @(negedge clock) begin
      if (reset) begin
         rsp_hold  = 0;
         rsp.ready = 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp.ready = 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
         rsp_hold = $urandom_range(1, 17) - 1;
         rsp.ready = 1'b0;
      end else begin
         rsp.ready = 1'b1;
      end
   end

   always @(posedge clock) begin
      word_exp_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_words.size() == 0) begin
            report("unexpected word", rsp.data.word, 64'h0);
         end else begin
            e = pending_words.pop_front();
            if (rsp.data.word !== e.word) report("word", rsp.data.word, e.word);
            if (rsp.data.last !== e.last) report("last", rsp.data.last, e.last);
         end
      end
   end

   task automatic drain();
      while (pending_words.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [0:0] index, input logic [63:0] value);
      drain();
      req.valid = 1'b0;
      csr.valid = 1'b1;
      csr.data  = '{index: index, value: value};
      do @(posedge clock); while (!csr.ready);
      if (index == sae_pkg::CsrBitWidth) cur_width = value[6:0];
      else cur_group = value[3:0];
      @(negedge clock);
      csr.valid = 1'b0;
   endtask

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_seed(input logic [63:0] lo, input logic [63:0] hi,
                            input bit typed, input logic [63:0] first_word);
      int gap;
      int first_idx;
      if (!calm && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 17);
         req.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req.valid = 1'b1;
      req.data  = '{seed_high: hi, seed_low: lo};
      do @(posedge clock); while (!req.ready);
      first_idx = pending_words.size();
      predict_words(lo, hi);
      if (typed) pending_words[first_idx].word = first_word;
      @(negedge clock);
      req.valid = 1'b0;
   endtask

   row_type rows [$];

   task automatic add_csr(input logic [0:0] index, input logic [63:0] value);
      row_type r;
      r = '{default: '0};
      r.is_csr = 1'b1; r.index = index; r.value = value;
      rows.push_back(r);
   endtask

   task automatic add_seed(input logic [63:0] lo, input logic [63:0] hi,
                           input bit typed, input logic [63:0] w);
      row_type r;
      r = '{default: '0};
      r.lo = lo; r.hi = hi; r.typed = typed; r.first_word = w;
      rows.push_back(r);
   endtask

   initial begin
      logic [63:0] lo, hi;
      errors    = 0;
      calm      = 1'b0;
      cur_width = 7'd64;
      cur_group = 4'd1;
      for (int i = 0; i < 256; i++) sub_table[i] = calc_sub(8'(i));
      reset     = 1'b1;
      req.valid = 1'b0;
      req.data  = '0;
      csr.valid = 1'b0;
      csr.data  = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset values: one full word equal to the low seed half
      add_seed(64'h0, 64'h0, 1, 64'h0);
      add_seed('1, '1, 1, '1);
      add_seed(64'h0123456789abcdef, 64'hfedcba9876543210, 1, 64'h0123456789abcdef);
      // zero width and zero group: one byte, one word
      add_csr(sae_pkg::CsrBitWidth, 64'h0);
      add_csr(sae_pkg::CsrGroupSize, 64'h0);
      add_seed(64'h00000000000000a5, '1, 1, 64'ha5);
      add_seed('1, 64'h0, 1, 64'hff);
      // wide width
      add_csr(sae_pkg::CsrBitWidth, 64'h7f);
      add_seed(64'h8000000000000001, 64'h0, 1, 64'h8000000000000001);
      // exactly sixteen bytes stays direct
      add_csr(sae_pkg::CsrBitWidth, 64'd16);
      add_csr(sae_pkg::CsrGroupSize, 64'd8);
      add_seed(64'h0706050403020100, 64'h0f0e0d0c0b0a0908, 1, 64'h0100);
      add_csr(sae_pkg::CsrBitWidth, 64'd1);
      add_seed('1, '1, 0, 0);
      // zero key, counter zero: first ciphertext bytes 66 e9 4b d4 ef 8a 2c 3b
      add_csr(sae_pkg::CsrBitWidth, 64'd64);
      add_csr(sae_pkg::CsrGroupSize, 64'd3);
      add_seed(64'h0, 64'h0, 1, 64'h3b2c8aefd44be966);
      add_seed('1, '1, 0, 0);
      // large group, upper register bits ignored
      add_csr(sae_pkg::CsrGroupSize, 64'hffff_ffff_ffff_fff9);
      add_seed(64'h0, 64'h0, 1, 64'h3b2c8aefd44be966);
      add_csr(sae_pkg::CsrBitWidth, 64'hffff_ffff_ffff_ff98);
      add_seed(64'h5555aaaa5555aaaa, 64'haaaa5555aaaa5555, 0, 0);
      add_csr(sae_pkg::CsrBitWidth, 64'd24);
      add_csr(sae_pkg::CsrGroupSize, 64'd6);
      add_seed(64'h1, 64'h2, 0, 0);

      foreach (rows[i]) begin
         if (rows[i].is_csr) write_reg(rows[i].index, rows[i].value);
         else send_seed(rows[i].lo, rows[i].hi, rows[i].typed, rows[i].first_word);
      end

      for (int k = 0; k < 300; k++) begin
         if (k % 40 == 0) begin
            case ($urandom_range(0, 3))
               0: write_reg(sae_pkg::CsrBitWidth, {$urandom, $urandom});
               1: write_reg(sae_pkg::CsrBitWidth, $urandom_range(0, 1) ? 64'd0 : 64'd127);
               default: write_reg(sae_pkg::CsrBitWidth, 64'($urandom_range(1, 64)));
            endcase
            case ($urandom_range(0, 3))
               0: write_reg(sae_pkg::CsrGroupSize, {$urandom, $urandom});
               1: write_reg(sae_pkg::CsrGroupSize, $urandom_range(0, 1) ? 64'd0 : 64'd15);
               default: write_reg(sae_pkg::CsrGroupSize, 64'($urandom_range(1, 8)));
            endcase
         end
         if (k == 150) drain();
         if (k == 260) calm = 1'b1;
         lo = {$urandom, $urandom};
         hi = {$urandom, $urandom};
         send_seed(lo, hi, 0, 0);
      end
      req.valid = 1'b0;
      drain();
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

/* seed_to_words_aes_expander.f */
src/sae_pkg.sv
src/sae_stream_if.sv
src/seed_to_words_aes_expander.sv
bench/seed_to_words_aes_expander_tb.sv
